FILE: hdl/jpv_pkg.sv
`timescale 1ns / 1ps

package jpv_pkg;

   // Array sizing default for the top level.
   localparam int MAX_JOINTS_DEF = 16;

   // Field widths.
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 4;
   localparam int COUNT_W  = 5;
   localparam int GAIN_W   = 16;
   localparam int LIMIT_W  = 31;
   localparam int STATUS_W = 2;

   // Configuration port.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Shared multiplier and accumulator sizing.
   localparam int MUL_A_W   = DATA_W + 1;
   localparam int MUL_B_W   = GAIN_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int GAIN_FRAC = 8;
   localparam int STEP_FRAC = 16;
   localparam int ACC_W     = PROD_W - GAIN_FRAC + 1;
   localparam int STEP_W    = PROD_W - STEP_FRAC;
   localparam int POS_SUM_W = STEP_W + 1;

   // Wide enough to hold any index compare against MAX_JOINTS up to 256.
   localparam int IDX_EXT_W = 9;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLE         = 3'd0,
      CSR_JOINT_COUNT    = 3'd1,
      CSR_POSITION_GAIN  = 3'd2,
      CSR_DAMPING_GAIN   = 3'd3,
      CSR_VELOCITY_LIMIT = 3'd4,
      CSR_STEP_PERIOD    = 3'd5
   } csr_index_type;

   localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOT_RUNNING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MUL_D,
      ST_CLAMP,
      ST_MUL_T,
      ST_WRITE,
      ST_OUT
   } state_type;

endpackage

FILE: hdl/jpv_if.sv
`timescale 1ns / 1ps

interface jpv_req_if import jpv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [INDEX_W-1:0]        joint_index;
   logic signed [DATA_W-1:0]  target_position;
   logic                      target_position_valid;
   logic signed [DATA_W-1:0]  feedforward_velocity;
   logic                      feedforward_valid;
   logic signed [DATA_W-1:0]  commanded_effort;
   logic                      effort_valid;

   modport source (
      output valid, joint_index, target_position, target_position_valid,
             feedforward_velocity, feedforward_valid, commanded_effort, effort_valid,
      input  ready
   );
   modport sink (
      input  valid, joint_index, target_position, target_position_valid,
             feedforward_velocity, feedforward_valid, commanded_effort, effort_valid,
      output ready
   );
endinterface

interface jpv_rsp_if import jpv_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic signed [DATA_W-1:0]  joint_position;
   logic signed [DATA_W-1:0]  joint_velocity;
   logic signed [DATA_W-1:0]  joint_effort;

   modport source (
      output valid, status, joint_position, joint_velocity, joint_effort,
      input  ready
   );
   modport sink (
      input  valid, status, joint_position, joint_velocity, joint_effort,
      output ready
   );
endinterface

interface jpv_csr_if import jpv_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_ADDR_W-1:0]  index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (
      output valid, index, data,
      input  ready
   );
   modport sink (
      input  valid, index, data,
      output ready
   );
endinterface

FILE: hdl/jpv_ram.sv
`timescale 1ns / 1ps

module jpv_ram #(
   parameter  int WIDTH  = 64,
   parameter  int DEPTH  = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/joint_pd_velocity_plant_step.sv
`timescale 1ns / 1ps

// Joint PD velocity plant. Each request beat updates one joint: the drive
// velocity kp*(target - position) + feedforward - kd*velocity is clamped to
// the velocity limit and stored, and velocity*dt is added to the stored
// position with saturation. A joint update steps through the states load,
// damping multiply, clamp, time-step multiply, write and output before the
// next accept; a rejected beat (block disabled or joint index out of range)
// goes straight to output. The sequence is set by one shared 33x17 signed
// multiplier used three times (position gain, damping gain, time step) with
// a register after each product, and by the registered joint state read.
// Position and velocity live in one memory with a valid bit per joint, so
// reset clears all joint state at once; configuration writes are taken in
// every cycle and must only occur while the block is idle.
module joint_pd_velocity_plant_step import jpv_pkg::*; #(
   parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   jpv_req_if.sink    req_bus,
   jpv_rsp_if.source  rsp_bus,
   jpv_csr_if.sink    csr_bus
);

   localparam int ADDR_W  = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
   localparam int ENTRY_W = 2 * DATA_W;

   state_type state_ff, state_in;

   // Configuration registers.
   logic                enable_ff;
   logic [COUNT_W-1:0]  joint_count_ff;
   logic [GAIN_W-1:0]   position_gain_ff;
   logic [GAIN_W-1:0]   damping_gain_ff;
   logic [LIMIT_W-1:0]  velocity_limit_ff;
   logic [GAIN_W-1:0]   step_period_ff;

   logic [MAX_JOINTS-1:0] entry_valid_ff;

   // Latched request.
   logic [ADDR_W-1:0]         addr_ff;
   logic signed [DATA_W-1:0]  target_ff;
   logic                      target_ok_ff;
   logic signed [DATA_W-1:0]  ff_term_ff;
   logic signed [DATA_W-1:0]  effort_ff;
   logic                      rd_valid_ff;

   // Datapath.
   logic signed [PROD_W-1:0]  product_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DATA_W-1:0]  vel_ff;

   // Response register.
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic signed [DATA_W-1:0]  rsp_pos_ff;
   logic signed [DATA_W-1:0]  rsp_vel_ff;
   logic signed [DATA_W-1:0]  rsp_eff_ff;

   logic                      req_fire;
   logic [IDX_EXT_W-1:0]      idx_ext;
   logic [ADDR_W-1:0]         req_addr;
   logic                      idx_in_range;
   logic [STATUS_W-1:0]       req_status;

   logic [ENTRY_W-1:0]        rd_data;
   logic [ENTRY_W-1:0]        wr_data;
   logic                      wr_en;
   logic signed [DATA_W-1:0]  pos_cur;
   logic signed [DATA_W-1:0]  vel_cur;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  mul_p;

   logic signed [ACC_W-1:0]   gain_term;
   logic signed [ACC_W-1:0]   drive;
   logic signed [ACC_W-1:0]   lim_pos;
   logic signed [ACC_W-1:0]   lim_neg;
   logic signed [DATA_W-1:0]  drive_clamped;

   logic signed [STEP_W-1:0]    step;
   logic signed [POS_SUM_W-1:0] pos_sum;
   logic signed [DATA_W-1:0]    pos_new;

   // ---------------------------------------------------------------------
   // Configuration port.
   // ---------------------------------------------------------------------
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff         <= 1'b0;
         joint_count_ff    <= COUNT_W'(1);
         position_gain_ff  <= '0;
         damping_gain_ff   <= '0;
         velocity_limit_ff <= '0;
         step_period_ff    <= '0;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_ENABLE:         enable_ff         <= csr_bus.data[0];
            CSR_JOINT_COUNT:    joint_count_ff    <= csr_bus.data[COUNT_W-1:0];
            CSR_POSITION_GAIN:  position_gain_ff  <= csr_bus.data[GAIN_W-1:0];
            CSR_DAMPING_GAIN:   damping_gain_ff   <= csr_bus.data[GAIN_W-1:0];
            CSR_VELOCITY_LIMIT: velocity_limit_ff <= csr_bus.data[LIMIT_W-1:0];
            CSR_STEP_PERIOD:    step_period_ff    <= csr_bus.data[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Request decode.
   // ---------------------------------------------------------------------
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign idx_ext      = {{(IDX_EXT_W-INDEX_W){1'b0}}, req_bus.joint_index};
   assign req_addr     = idx_ext[ADDR_W-1:0];
   assign idx_in_range = ({1'b0, req_bus.joint_index} < joint_count_ff)
                         && (idx_ext < IDX_EXT_W'(MAX_JOINTS));

   always_comb begin
      priority if (!enable_ff) begin
         req_status = STATUS_NOT_RUNNING;
      end else if (!idx_in_range) begin
         req_status = STATUS_BAD_INDEX;
      end else begin
         req_status = STATUS_OK;
      end
   end

   // ---------------------------------------------------------------------
   // Joint state memory: {position, velocity} per joint.
   // ---------------------------------------------------------------------
   jpv_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_JOINTS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr_ff),
      .wr_data (wr_data),
      .rd_en   (req_fire),
      .rd_addr (req_addr),
      .rd_data (rd_data)
   );

   // A joint never written since reset reads as zero.
   assign pos_cur = rd_valid_ff ? $signed(rd_data[ENTRY_W-1:DATA_W]) : '0;
   assign vel_cur = rd_valid_ff ? $signed(rd_data[DATA_W-1:0]) : '0;
   assign wr_data = {pos_new, vel_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
      end else if (wr_en) begin
         entry_valid_ff[addr_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_bus.ready = 1'b0;
      rsp_bus.valid = 1'b0;
      wr_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               state_in = (req_status == STATUS_OK) ? ST_LOAD : ST_OUT;
            end
         end
         ST_LOAD:  state_in = ST_MUL_D;
         ST_MUL_D: state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_MUL_T;
         ST_MUL_T: state_in = ST_WRITE;
         ST_WRITE: begin
            wr_en    = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            rsp_bus.valid = 1'b1;
            if (rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Shared multiplier: operands selected by the sequencer step.
   // ---------------------------------------------------------------------
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LOAD: begin
            if (target_ok_ff) begin
               mul_a = MUL_A_W'(target_ff) - MUL_A_W'(pos_cur);
            end
            mul_b = $signed({1'b0, position_gain_ff});
         end
         ST_MUL_D: begin
            mul_a = MUL_A_W'(vel_cur);
            mul_b = $signed({1'b0, damping_gain_ff});
         end
         ST_MUL_T: begin
            mul_a = MUL_A_W'(vel_ff);
            mul_b = $signed({1'b0, step_period_ff});
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Floor division by 2^8 is an arithmetic shift of the product.
   assign gain_term = ACC_W'($signed(product_ff[PROD_W-1:GAIN_FRAC]));
   assign drive     = acc_ff - gain_term;
   assign lim_pos   = ACC_W'($signed({1'b0, velocity_limit_ff}));
   assign lim_neg   = -lim_pos;

   always_comb begin
      priority if (drive > lim_pos) begin
         drive_clamped = DATA_W'(lim_pos);
      end else if (drive < lim_neg) begin
         drive_clamped = DATA_W'(lim_neg);
      end else begin
         drive_clamped = DATA_W'(drive);
      end
   end

   assign step    = $signed(product_ff[PROD_W-1:STEP_FRAC]);
   assign pos_sum = POS_SUM_W'(pos_cur) + POS_SUM_W'(step);

   always_comb begin
      priority if (pos_sum > POS_SUM_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}))) begin
         pos_new = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (pos_sum < POS_SUM_W'(signed'({1'b1, {(DATA_W-1){1'b0}}}))) begin
         pos_new = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         pos_new = DATA_W'(pos_sum);
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire) begin
         addr_ff      <= req_addr;
         target_ff    <= req_bus.target_position;
         target_ok_ff <= req_bus.target_position_valid;
         ff_term_ff   <= req_bus.feedforward_valid ? req_bus.feedforward_velocity : '0;
         effort_ff    <= req_bus.effort_valid ? req_bus.commanded_effort : '0;
         rd_valid_ff  <= entry_valid_ff[req_addr];
      end
      product_ff <= mul_p;
      unique case (state_ff)
         ST_LOAD:  acc_ff <= ACC_W'(ff_term_ff);
         ST_MUL_D: acc_ff <= acc_ff + gain_term;
         ST_CLAMP: vel_ff <= drive_clamped;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Response register.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_fire && (req_status != STATUS_OK)) begin
         rsp_status_ff <= req_status;
         rsp_pos_ff    <= '0;
         rsp_vel_ff    <= '0;
         rsp_eff_ff    <= '0;
      end else if (state_ff == ST_WRITE) begin
         rsp_status_ff <= STATUS_OK;
         rsp_pos_ff    <= pos_new;
         rsp_vel_ff    <= vel_ff;
         rsp_eff_ff    <= effort_ff;
      end
   end

   assign rsp_bus.status         = rsp_status_ff;
   assign rsp_bus.joint_position = rsp_pos_ff;
   assign rsp_bus.joint_velocity = rsp_vel_ff;
   assign rsp_bus.joint_effort   = rsp_eff_ff;

endmodule

FILE: hdl/jpv_checker.sv
`timescale 1ns / 1ps

module jpv_checker import jpv_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [STATUS_W-1:0]       rsp_status,
   input logic signed [DATA_W-1:0]  rsp_position,
   input logic signed [DATA_W-1:0]  rsp_velocity,
   input logic signed [DATA_W-1:0]  rsp_effort
);

   // One joint at a time: after a request beat the block stops taking more.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while a joint update is in flight");

   // The block never takes a request while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready))
      else $error("request ready while a response beat is pending");

   // A rejected beat carries all-zero joint fields.
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK))
      |-> ((rsp_position == '0) && (rsp_velocity == '0) && (rsp_effort == '0)))
      else $error("rejected response carries nonzero joint data");

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
      && $stable(rsp_position) && $stable(rsp_velocity) && $stable(rsp_effort)))
      else $error("response beat changed while stalled");

endmodule

bind joint_pd_velocity_plant_step jpv_checker u_jpv_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_status   (rsp_bus.status),
   .rsp_position (rsp_bus.joint_position),
   .rsp_velocity (rsp_bus.joint_velocity),
   .rsp_effort   (rsp_bus.joint_effort)
);
